@@ src/rem_pkg.sv @@
// shared widths, register codes, configuration struct and exp level table for the ellipse mask
package rem_pkg;

  // field widths
  localparam int unsigned CoordW  = 12;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned InvW    = 24;
  localparam int unsigned LevelW  = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;

  // datapath widths
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = DiffW + AngleW;
  localparam int unsigned RotW    = ProdW + 1;
  localparam int unsigned MagW    = RotW - 1;
  localparam int unsigned ScaledW = MagW + InvW;
  localparam int unsigned ScaleShift = 18;
  localparam int unsigned ClampW  = 29;
  localparam int unsigned SqW     = 2 * ClampW;
  localparam int unsigned QW      = SqW + 1;

  // exp argument handling
  localparam int unsigned QShift   = 16;
  localparam int unsigned Q16W     = QW - QShift;
  localparam int unsigned Q16KeepW = 36;
  localparam int unsigned HalfW    = Q16KeepW / 2;
  localparam int unsigned PartW    = HalfW + InvW;
  localparam int unsigned TW       = Q16KeepW + InvW;
  localparam int unsigned ArgFracW = 16;
  localparam int unsigned ArgIntW  = 4;
  localparam int unsigned ArgW     = ArgFracW + ArgIntW;

  // exp table
  localparam int unsigned ExpTableDepth = 256;
  localparam int unsigned ExpIdxW       = $clog2(ExpTableDepth);

  localparam logic [LevelW-1:0] FullScale = LevelW'(65536);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_ROW   = 3'd0,
    REG_CENTER_COL   = 3'd1,
    REG_COS_ANGLE    = 3'd2,
    REG_SIN_ANGLE    = 3'd3,
    REG_INV_MAJOR    = 3'd4,
    REG_INV_MINOR    = 3'd5,
    REG_INV_SIGMA_SQ = 3'd6,
    REG_INVERT_MASK  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0]        center_row;
    logic [CoordW-1:0]        center_col;
    logic signed [AngleW-1:0] cos_angle;
    logic signed [AngleW-1:0] sin_angle;
    logic [InvW-1:0]          inv_major;
    logic [InvW-1:0]          inv_minor;
    logic [InvW-1:0]          inv_sigma_sq;
    logic                     invert_mask;
  } cfg_t;

  typedef logic [LevelW-1:0] exp_table_t [ExpTableDepth];

  // exp(-k*h) levels, h = 16 / depth, worked out at elaboration
  function automatic exp_table_t build_exp_table();
    logic [63:0] hq;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] ratio;
    logic [63:0] acc;
    exp_table_t  tab;
    hq   = (64'd16 << 32) / 64'(ExpTableDepth);
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * (hq >> 1)) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    ratio = sum;
    acc   = 64'd1 << 32;
    for (int k = 0; k < ExpTableDepth; k++) begin
      if (k > 0) begin
        acc = (acc * ratio) >> 32;
      end
      tab[k] = LevelW'((acc + 64'd32768) >> 16);
    end
    return tab;
  endfunction

endpackage

@@ src/rotated_ellipse_mask_pixel_unit.sv @@
// rotated ellipse mask: configuration registers and nine stage pixel pipeline
// an accepted request passes the rotate, scale and level stages on its way to its mask level at the output
// throughput: one pixel per cycle while the output is not stalled, each stage with its own register
// a stalled output holds its level while empty stages further up keep taking requests
// reset: all stage valid bits clear and the configuration registers take their reset values
module rotated_ellipse_mask_pixel_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rem_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rem_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rem_pkg::CoordW-1:0]    pixel_row_i,
  input  logic [rem_pkg::CoordW-1:0]    pixel_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rem_pkg::LevelW-1:0]    mask_level_o
);

  rem_pkg::cfg_t cfg_d, cfg_q;

  logic                       rot_valid, rot_ready;
  logic [rem_pkg::MagW-1:0]   mag_col, mag_row;
  logic                       scl_valid, scl_ready;
  logic [rem_pkg::QW-1:0]     q;

  // configuration write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rem_pkg::reg_idx_e'(cfg_idx_i))
        rem_pkg::REG_CENTER_ROW:   cfg_d.center_row   = cfg_wdata_i[rem_pkg::CoordW-1:0];
        rem_pkg::REG_CENTER_COL:   cfg_d.center_col   = cfg_wdata_i[rem_pkg::CoordW-1:0];
        rem_pkg::REG_COS_ANGLE:    cfg_d.cos_angle    = $signed(cfg_wdata_i[rem_pkg::AngleW-1:0]);
        rem_pkg::REG_SIN_ANGLE:    cfg_d.sin_angle    = $signed(cfg_wdata_i[rem_pkg::AngleW-1:0]);
        rem_pkg::REG_INV_MAJOR:    cfg_d.inv_major    = cfg_wdata_i[rem_pkg::InvW-1:0];
        rem_pkg::REG_INV_MINOR:    cfg_d.inv_minor    = cfg_wdata_i[rem_pkg::InvW-1:0];
        rem_pkg::REG_INV_SIGMA_SQ: cfg_d.inv_sigma_sq = cfg_wdata_i[rem_pkg::InvW-1:0];
        rem_pkg::REG_INVERT_MASK:  cfg_d.invert_mask  = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_row   <= '0;
      cfg_q.center_col   <= '0;
      cfg_q.cos_angle    <= rem_pkg::AngleW'(16384);
      cfg_q.sin_angle    <= '0;
      cfg_q.inv_major    <= rem_pkg::InvW'(1048576);
      cfg_q.inv_minor    <= rem_pkg::InvW'(1048576);
      cfg_q.inv_sigma_sq <= '0;
      cfg_q.invert_mask  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // offset and rotation
  rem_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .mag_col_o   (mag_col),
    .mag_row_o   (mag_row)
  );

  // axis scaling and sum of squares
  rem_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .mag_col_i   (mag_col),
    .mag_row_i   (mag_row),
    .out_valid_o (scl_valid),
    .out_ready_i (scl_ready),
    .q_o         (q)
  );

  // mask level
  rem_level u_level (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (scl_valid),
    .in_ready_o   (scl_ready),
    .q_i          (q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mask_level_o (mask_level_o)
  );

endmodule

@@ src/rem_rotate.sv @@
// centre offset and rotation stages: offsets, partial products, rotated magnitudes
module rem_rotate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rem_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rem_pkg::CoordW-1:0]  pixel_row_i,
  input  logic [rem_pkg::CoordW-1:0]  pixel_col_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rem_pkg::MagW-1:0]    mag_col_o,
  output logic [rem_pkg::MagW-1:0]    mag_row_o
);

  localparam int unsigned DiffW = rem_pkg::DiffW;
  localparam int unsigned ProdW = rem_pkg::ProdW;
  localparam int unsigned RotW  = rem_pkg::RotW;
  localparam int unsigned MagW  = rem_pkg::MagW;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [DiffW-1:0] dr_d, dc_d, dr_q, dc_q;
  logic signed [rem_pkg::AngleW-1:0] cos_s, sin_s;
  logic signed [ProdW-1:0] p_rc_d, p_rs_d, p_cc_d, p_cs_d;
  logic signed [ProdW-1:0] p_rc_q, p_rs_q, p_cc_q, p_cs_q;
  logic signed [RotW-1:0]  cr_d, rr_d;
  logic [MagW-1:0]         mag_c_d, mag_r_d, mag_c_q, mag_r_q;

  // stage ready chain
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // centre offsets
  assign dr_d = $signed({1'b0, pixel_row_i}) - $signed({1'b0, cfg_i.center_row});
  assign dc_d = $signed({1'b0, pixel_col_i}) - $signed({1'b0, cfg_i.center_col});

  // rotation partial products
  assign cos_s  = cfg_i.cos_angle;
  assign sin_s  = cfg_i.sin_angle;
  assign p_rc_d = dr_q * cos_s;
  assign p_rs_d = dr_q * sin_s;
  assign p_cc_d = dc_q * cos_s;
  assign p_cs_d = dc_q * sin_s;

  // rotated offsets and their magnitudes
  assign cr_d    = RotW'(p_cc_q) + RotW'(p_rs_q);
  assign rr_d    = RotW'(p_rc_q) - RotW'(p_cs_q);
  assign mag_c_d = cr_d[RotW-1] ? MagW'(-cr_d) : MagW'(cr_d);
  assign mag_r_d = rr_d[RotW-1] ? MagW'(-rr_d) : MagW'(rr_d);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      dr_q <= dr_d;
      dc_q <= dc_d;
    end
    if (rdy2 && v1_q) begin
      p_rc_q <= p_rc_d;
      p_rs_q <= p_rs_d;
      p_cc_q <= p_cc_d;
      p_cs_q <= p_cs_d;
    end
    if (rdy3 && v2_q) begin
      mag_c_q <= mag_c_d;
      mag_r_q <= mag_r_d;
    end
  end

  assign out_valid_o = v3_q;
  assign mag_col_o   = mag_c_q;
  assign mag_row_o   = mag_r_q;

endmodule

@@ src/rem_scale.sv @@
// axis scaling, clamp and squaring stages giving the squared ellipse radius q in Q32
module rem_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rem_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rem_pkg::MagW-1:0]    mag_col_i,
  input  logic [rem_pkg::MagW-1:0]    mag_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rem_pkg::QW-1:0]      q_o
);

  localparam int unsigned ScaledW = rem_pkg::ScaledW;
  localparam int unsigned ClampW  = rem_pkg::ClampW;
  localparam int unsigned SqW     = rem_pkg::SqW;
  localparam int unsigned QW      = rem_pkg::QW;
  localparam int unsigned ShW     = ScaledW - rem_pkg::ScaleShift;
  localparam logic [ShW-1:0] ClampMax = ShW'(1) << (ClampW - 1);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [ScaledW-1:0] pc_d, pr_d, pc_q, pr_q;
  logic [ShW-1:0]     shc, shr;
  logic [ClampW-1:0]  sc, sr;
  logic [SqW-1:0]     sqc_d, sqr_d, sqc_q, sqr_q;
  logic [QW-1:0]      q_d, q_q;

  // stage ready chain
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // scale by reciprocal semi-axes
  assign pc_d = ScaledW'(mag_col_i) * ScaledW'(cfg_i.inv_major);
  assign pr_d = ScaledW'(mag_row_i) * ScaledW'(cfg_i.inv_minor);

  // truncate to Q16, clamp, square
  assign shc   = pc_q[ScaledW-1:rem_pkg::ScaleShift];
  assign shr   = pr_q[ScaledW-1:rem_pkg::ScaleShift];
  assign sc    = (shc > ClampMax) ? ClampW'(ClampMax) : ClampW'(shc);
  assign sr    = (shr > ClampMax) ? ClampW'(ClampMax) : ClampW'(shr);
  assign sqc_d = SqW'(sc) * SqW'(sc);
  assign sqr_d = SqW'(sr) * SqW'(sr);

  // sum of squares
  assign q_d = QW'(sqc_q) + QW'(sqr_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      pc_q <= pc_d;
      pr_q <= pr_d;
    end
    if (rdy2 && v1_q) begin
      sqc_q <= sqc_d;
      sqr_q <= sqr_d;
    end
    if (rdy3 && v2_q) begin
      q_q <= q_d;
    end
  end

  assign out_valid_o = v3_q;
  assign q_o         = q_q;

endmodule

@@ src/rem_level.sv @@
// mask level stages: exp argument, table index, table read and final level select
module rem_level (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rem_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rem_pkg::QW-1:0]       q_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rem_pkg::LevelW-1:0]   mask_level_o
);

  localparam int unsigned QW       = rem_pkg::QW;
  localparam int unsigned Q16W     = rem_pkg::Q16W;
  localparam int unsigned KeepW    = rem_pkg::Q16KeepW;
  localparam int unsigned HalfW    = rem_pkg::HalfW;
  localparam int unsigned PartW    = rem_pkg::PartW;
  localparam int unsigned TW       = rem_pkg::TW;
  localparam int unsigned ArgW     = rem_pkg::ArgW;
  localparam int unsigned ArgFracW = rem_pkg::ArgFracW;
  localparam int unsigned IdxW     = rem_pkg::ExpIdxW;
  localparam int unsigned LevelW   = rem_pkg::LevelW;
  localparam int unsigned Depth    = rem_pkg::ExpTableDepth;
  localparam int unsigned IdxShift = ArgW;
  localparam int unsigned IdxSumW  = ArgW + IdxW + 1;
  localparam logic [IdxSumW-1:0] IdxRound = IdxSumW'(1) << (IdxShift - 1);
  localparam rem_pkg::exp_table_t ExpTable = rem_pkg::build_exp_table();

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // stage 1 signals
  logic [Q16W-1:0]  q16;
  logic [HalfW-1:0] q_hi, q_lo;
  logic             inside_d, big_d;
  logic [PartW-1:0] ph_d, pl_d, ph_q, pl_q;
  logic             inside1_q, big_q;

  // stage 2 signals
  logic [TW-1:0]        t;
  logic [ArgW-1:0]      t16;
  logic [IdxSumW-1:0]   idx_sum;
  logic [IdxW:0]        idx_full;
  logic                 zero_d, zero_q, inside2_q;
  logic [IdxW-1:0]      idx_d, idx_q;

  // stage 3 signals
  logic [LevelW-1:0] e, level_d, level_q;
  logic              hard;

  // stage ready chain
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // inside test and split product q16 * inv_sigma_sq
  assign inside_d = (q_i[QW-1:32] == '0);
  assign q16      = q_i[QW-1:rem_pkg::QShift];
  assign big_d    = (q16[Q16W-1:KeepW] != '0);
  assign q_hi     = q16[KeepW-1:HalfW];
  assign q_lo     = q16[HalfW-1:0];
  assign ph_d     = PartW'(q_hi) * PartW'(cfg_i.inv_sigma_sq);
  assign pl_d     = PartW'(q_lo) * PartW'(cfg_i.inv_sigma_sq);

  // recombine, range check and rounded table index
  assign t        = (TW'(ph_q) << HalfW) + TW'(pl_q);
  assign t16      = t[ArgW+ArgFracW-1:ArgFracW];
  assign idx_sum  = IdxSumW'(t16) * IdxSumW'(Depth) + IdxRound;
  assign idx_full = idx_sum[IdxSumW-1:IdxShift];
  assign zero_d   = big_q || (t[TW-1:ArgW+ArgFracW] != '0)
                    || (idx_full >= (IdxW+1)'(Depth));
  assign idx_d    = idx_full[IdxW-1:0];

  // table read and level select
  assign hard = (cfg_i.inv_sigma_sq == '0);
  assign e    = zero_q ? '0 : ExpTable[idx_q];
  always_comb begin
    if (hard) begin
      level_d = (inside2_q != cfg_i.invert_mask) ? rem_pkg::FullScale : '0;
    end else if (cfg_i.invert_mask) begin
      level_d = rem_pkg::FullScale - e;
    end else begin
      level_d = e;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ph_q      <= ph_d;
      pl_q      <= pl_d;
      big_q     <= big_d;
      inside1_q <= inside_d;
    end
    if (rdy2 && v1_q) begin
      idx_q     <= idx_d;
      zero_q    <= zero_d;
      inside2_q <= inside1_q;
    end
    if (rdy3 && v2_q) begin
      level_q <= level_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign mask_level_o = level_q;

endmodule

@@ test/rem_mask_check_pkg.sv @@
// level predictor and result checker for the ellipse mask testbench
`timescale 1ns / 1ps

package rem_mask_check_pkg;

  import rem_pkg::*;

  class mask_level_checker;

    // register copy
    logic [CoordW-1:0] center_row;
    logic [CoordW-1:0] center_col;
    shortint           cos_angle;
    shortint           sin_angle;
    logic [InvW-1:0]   inv_major;
    logic [InvW-1:0]   inv_minor;
    logic [InvW-1:0]   inv_sigma_sq;
    logic              invert_mask;

    longint unsigned   exp_level [ExpTableDepth];
    logic [LevelW-1:0] expected_levels [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      longint unsigned step_q;
      longint unsigned term;
      longint unsigned series;
      longint unsigned ratio;
      longint unsigned acc;
      center_row   = '0;
      center_col   = '0;
      cos_angle    = 16384;
      sin_angle    = 0;
      inv_major    = 24'd1048576;
      inv_minor    = 24'd1048576;
      inv_sigma_sq = '0;
      invert_mask  = 1'b0;
      errors       = 0;
      checked      = 0;
      // exp(-h) as an alternating series in Q32, then powers of it
      step_q = (64'd16 << 32) / 64'(ExpTableDepth);
      term   = 64'd1 << 32;
      series = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * (step_q >> 1)) >> 31) / 64'(n);
        if (n % 2 == 1) begin
          series = (series >= term) ? series - term : 64'd0;
        end else begin
          series = series + term;
        end
      end
      ratio = series;
      acc   = 64'd1 << 32;
      for (int k = 0; k < ExpTableDepth; k++) begin
        if (k > 0) begin
          acc = (acc * ratio) >> 32;
        end
        exp_level[k] = (acc + 64'd32768) >> 16;
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        REG_CENTER_ROW:   center_row   = data[CoordW-1:0];
        REG_CENTER_COL:   center_col   = data[CoordW-1:0];
        REG_COS_ANGLE:    cos_angle    = shortint'(data[AngleW-1:0]);
        REG_SIN_ANGLE:    sin_angle    = shortint'(data[AngleW-1:0]);
        REG_INV_MAJOR:    inv_major    = data[InvW-1:0];
        REG_INV_MINOR:    inv_minor    = data[InvW-1:0];
        REG_INV_SIGMA_SQ: inv_sigma_sq = data[InvW-1:0];
        REG_INVERT_MASK:  invert_mask  = data[0];
        default: ;
      endcase
    endfunction

    // square of |v| * inv in Q16, clamped to 2^28 before squaring
    function longint unsigned scaled_square(longint v, logic [InvW-1:0] inv);
      longint unsigned mag;
      longint unsigned s;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      s   = (mag * inv) >> 18;
      if (s > (64'd1 << 28)) begin
        s = 64'd1 << 28;
      end
      return s * s;
    endfunction

    function logic [LevelW-1:0] level_for_pixel(logic [CoordW-1:0] row,
                                                logic [CoordW-1:0] col);
      longint          r;
      longint          c;
      longint          dr;
      longint          dc;
      longint          cr;
      longint          rr;
      longint unsigned q;
      longint unsigned q16;
      longint unsigned t16;
      longint unsigned idx;
      longint unsigned e;
      logic            in_ellipse;
      r  = row;
      c  = col;
      dr = r - longint'(center_row);
      dc = c - longint'(center_col);
      cr = dc * cos_angle + dr * sin_angle;
      rr = dr * cos_angle - dc * sin_angle;
      q  = scaled_square(cr, inv_major) + scaled_square(rr, inv_minor);
      // hard mask: inside below one in Q32
      if (inv_sigma_sq == '0) begin
        in_ellipse = (q < (64'd1 << 32));
        return (in_ellipse != invert_mask) ? FullScale : '0;
      end
      // soft mask: table lookup of exp(-q / sigma^2)
      q16 = q >> 16;
      if (q16 > (64'd1 << 40)) begin
        q16 = 64'd1 << 40;
      end
      t16 = (q16 * inv_sigma_sq) >> 16;
      e   = 0;
      if (t16 < (64'd16 << 16)) begin
        idx = (t16 * 64'(ExpTableDepth) + (64'd1 << 19)) >> 20;
        if (idx < 64'(ExpTableDepth)) begin
          e = exp_level[idx];
        end
      end
      return invert_mask ? LevelW'(64'd65536 - e) : LevelW'(e);
    endfunction

    function void note_request(logic [CoordW-1:0] row, logic [CoordW-1:0] col);
      expected_levels.push_back(level_for_pixel(row, col));
    endfunction

    function void check_level(logic [LevelW-1:0] got);
      logic [LevelW-1:0] want;
      if (expected_levels.size() == 0) begin
        $display("%0t: mask level %0d with no request pending", $time, got);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: mask level expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

  endclass

endpackage

@@ test/tb_rotated_ellipse_mask_pixel_unit.sv @@
// testbench for the rotated ellipse mask pixel unit
`timescale 1ns / 1ps

module tb_rotated_ellipse_mask_pixel_unit;

  import rem_pkg::*;
  import rem_mask_check_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned Latency       = 9;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned ItemsPerPhase = 66;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [CfgW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [CoordW-1:0] pixel_row_i = '0;
  logic [CoordW-1:0] pixel_col_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [LevelW-1:0] mask_level_o;

  mask_level_checker sb = new();

  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 59;
  int unsigned cycles        = 0;
  int unsigned settings      = 1;
  int          reach         = 64;
  logic [CoordW-1:0] cur_row = '0;
  logic [CoordW-1:0] cur_col = '0;

  // unit rotations in Q1.14, first quadrant
  shortint unit_cos [8] = '{16384, 0, 11585, 14189, 8192, 15137, 6270, 16069};
  shortint unit_sin [8] = '{0, 16384, 11585, 8192, 14189, 6270, 15137, 3196};

  rotated_ellipse_mask_pixel_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mask_level_o (mask_level_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted requests and results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(pixel_row_i, pixel_col_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_level(mask_level_o);
      end
    end
  end

  // run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("rotated_ellipse_mask_pixel_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_setting(logic [CoordW-1:0] crow, logic [CoordW-1:0] ccol,
                               logic [AngleW-1:0] cs, logic [AngleW-1:0] sn,
                               logic [InvW-1:0] imaj, logic [InvW-1:0] imin,
                               logic [InvW-1:0] isig, logic inv);
    write_reg(REG_CENTER_ROW, CfgW'(crow));
    write_reg(REG_CENTER_COL, CfgW'(ccol));
    write_reg(REG_COS_ANGLE, CfgW'(cs));
    write_reg(REG_SIN_ANGLE, CfgW'(sn));
    write_reg(REG_INV_MAJOR, imaj);
    write_reg(REG_INV_MINOR, imin);
    write_reg(REG_INV_SIGMA_SQ, isig);
    write_reg(REG_INVERT_MASK, CfgW'(inv));
    cur_row = crow;
    cur_col = ccol;
    settings++;
  endtask

  // one request, with random idle cycles ahead of it
  task automatic send_pixel(logic [CoordW-1:0] row, logic [CoordW-1:0] col);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_row_i <= row;
    pixel_col_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and let every pending level come out
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] near(logic [CoordW-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return CoordW'(v);
  endfunction

  // random geometry, mostly sensible ellipses with a few odd register values
  task automatic random_setting();
    int                unsigned pick;
    int                ax_major;
    int                ax_minor;
    logic [AngleW-1:0] cs;
    logic [AngleW-1:0] sn;
    logic [InvW-1:0]   imaj;
    logic [InvW-1:0]   imin;
    logic [InvW-1:0]   isig;
    pick = $urandom_range(7);
    cs   = unit_cos[pick];
    sn   = unit_sin[pick];
    if ($urandom_range(1) == 1) cs = -cs;
    if ($urandom_range(1) == 1) sn = -sn;
    if ($urandom_range(4) == 0) begin
      cs = AngleW'($urandom);
      sn = AngleW'($urandom);
    end
    ax_major = $urandom_range(2, 600);
    ax_minor = $urandom_range(2, ax_major);
    imaj = InvW'((1 << 20) / ax_major);
    imin = InvW'((1 << 20) / ax_minor);
    if ($urandom_range(9) == 0) imaj = InvW'($urandom);
    if ($urandom_range(9) == 0) imin = '0;
    case ($urandom_range(2))
      0:       isig = '0;
      default: isig = InvW'($urandom_range(24'h400, 24'h40000));
    endcase
    if ($urandom_range(9) == 0) isig = InvW'($urandom);
    reach = ax_major * int'($urandom_range(1, 6));
    if (reach > 4095) reach = 4095;
    apply_setting(CoordW'($urandom), CoordW'($urandom), cs, sn, imaj, imin, isig,
                  1'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: unit circle at the origin, hard edge
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    wait_for_results();

    // extreme registers: sine and cosine beyond one, huge arguments, zero inverse minor axis
    apply_setting(12'd4095, 12'd4095, 16'h8000, 16'h7FFF, 24'hFFFFFF, 24'd0,
                  24'hFFFFFF, 1'b1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd4094);
    send_pixel(12'd0, 12'd4095);
    wait_for_results();

    // soft edge at 45 degrees, sigma of one
    apply_setting(12'd2048, 12'd2048, 16'd11585, 16'd11585, 24'd16384, 24'd65536,
                  24'd65536, 1'b0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2058, 12'd2058);
    send_pixel(12'd2100, 12'd2000);
    send_pixel(12'd2048, 12'd2112);
    send_pixel(12'd2060, 12'd2030);
    wait_for_results();

    // inverted hard mask, rotated by minus 90 degrees
    apply_setting(12'd100, 12'd3000, 16'd0, 16'hC000, 24'd26214, 24'd52428,
                  24'd0, 1'b1);
    send_pixel(12'd100, 12'd3000);
    send_pixel(12'd100, 12'd3040);
    send_pixel(12'd140, 12'd3000);
    send_pixel(12'd4095, 12'd0);
    wait_for_results();

    // random geometry and pixels, idling pattern changes every four phases
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 30;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting();
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 5 && n == ItemsPerPhase / 2) begin
          wait_for_results();
        end
        if ($urandom_range(9) < 7) begin
          send_pixel(near(cur_row), near(cur_col));
        end else begin
          send_pixel(CoordW'($urandom), CoordW'($urandom));
        end
      end
      wait_for_results();
    end

    repeat (2 * Latency) @(posedge clk_i);
    $display("%0d mask levels checked over %0d register settings,", sb.checked, settings);
    $display("hard and soft edges, both polarities, extreme and random geometry");
    if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
      $display("rotated_ellipse_mask_pixel_unit: match");
    end else begin
      $display("rotated_ellipse_mask_pixel_unit: mismatch");
    end
    $finish;
  end

endmodule
